@@ hw/rtl/buffered_channel_with_wait_queues_assert.svh @@
// Assertion macros shared by the channel checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BUFFERED_CHANNEL_WITH_WAIT_QUEUES_ASSERT_SVH
`define BUFFERED_CHANNEL_WITH_WAIT_QUEUES_ASSERT_SVH

// Property that must hold at every sampled edge outside reset
`define BCWQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("channel assertion failed");

// Antecedent in one cycle implies consequent in the next
`define BCWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("channel next-cycle assertion failed");

`endif

@@ hw/rtl/bcwq_pkg.sv @@
// Shared types and codes for the buffered channel with wait queues.
// No dependencies; used by the interfaces and all modules.
package bcwq_pkg;

  localparam int unsigned FIELD_W = 64;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned LIMIT_W = 5;

  // Request kinds
  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_RECV = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_CONTINUE = 2'd0,
    STAT_SUSPEND  = 2'd1,
    STAT_QFULL    = 2'd2
  } status_e;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    task_id;
    logic [FIELD_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               read_valid;
    logic [FIELD_W-1:0] read_value;
    logic               wake_valid;
    logic [ID_W-1:0]    wake_id;
    logic               wake_at_front;
    logic               wake_value_valid;
    logic [FIELD_W-1:0] wake_value;
    logic               caller_requeued;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic commit;   // apply state update and load the result register
  } ctrl_cmd_t;

endpackage

@@ hw/rtl/bcwq_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on bcwq_pkg for the payload types.
interface bcwq_in_if
  import bcwq_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bcwq_out_if
  import bcwq_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/bcwq_ctrl.sv @@
// Sequencing controller: accept, fetch queue heads, execute and hand off.
// Depends on bcwq_pkg for state and command types.
module bcwq_ctrl
  import bcwq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, commit;

  assign in_ready_o = (state_q == S_IDLE) && rst_ni;
  assign accept     = in_valid_i && in_ready_o;
  // result register is free when empty or being drained this cycle
  assign commit     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign cmd_o.capture = accept;
  assign cmd_o.commit  = commit;
  assign out_valid_o   = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_FETCH;
      S_FETCH: state_d = S_EXEC;
      S_EXEC:  if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/bcwq_datapath.sv @@
// Datapath: value buffer and wait queue memories, pointers, decision logic
// and result register. Depends on bcwq_pkg; driven by bcwq_ctrl commands.
module bcwq_datapath
  import bcwq_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 16,
  parameter int unsigned WAIT_DEPTH   = 16,
  parameter int unsigned DATA_WIDTH   = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  input  in_item_t           in_item_i,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  output out_item_t          out_item_o
);

  localparam int unsigned VPW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned VCW  = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned VSW  = ((VPW > VCW) ? VPW : VCW) + 1;
  localparam int unsigned WPW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned WCW  = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned WSW  = ((WPW > WCW) ? WPW : WCW) + 1;
  localparam int unsigned CAPW = (VCW > LIMIT_W) ? VCW : LIMIT_W;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(16);

  // storage
  logic [DATA_WIDTH-1:0] vmem      [BUFFER_DEPTH];
  logic [ID_W-1:0]       smem_id   [WAIT_DEPTH];
  logic [DATA_WIDTH-1:0] smem_val  [WAIT_DEPTH];
  logic [ID_W-1:0]       rmem_id   [WAIT_DEPTH];

  // head read registers
  logic [DATA_WIDTH-1:0] vrd_q, sval_q;
  logic [ID_W-1:0]       sid_q, rid_q;

  // captured request
  logic                  kind_q;
  logic [ID_W-1:0]       id_q;
  logic [DATA_WIDTH-1:0] data_q;

  // control state
  logic [LIMIT_W-1:0] limit_q;
  logic [VCW-1:0]     vcount_q, vcount_d;
  logic [VPW-1:0]     vhead_q, vhead_d;
  logic [WCW-1:0]     scount_q, scount_d, rcount_q, rcount_d;
  logic [WPW-1:0]     shead_q, shead_d, rhead_q, rhead_d;

  out_item_t out_q, res;

  // tails and wrapped increments
  logic [VSW-1:0] vsum;
  logic [WSW-1:0] ssum, rsum;
  logic [VPW-1:0] vtail, vhead_inc;
  logic [WPW-1:0] stail, rtail, shead_inc, rhead_inc;
  logic [VPW:0]   vinc;
  logic [WPW:0]   sinc, rinc;

  assign vsum  = VSW'(vhead_q) + VSW'(vcount_q);
  assign vtail = (vsum >= VSW'(BUFFER_DEPTH)) ? VPW'(vsum - VSW'(BUFFER_DEPTH)) : VPW'(vsum);
  assign ssum  = WSW'(shead_q) + WSW'(scount_q);
  assign stail = (ssum >= WSW'(WAIT_DEPTH)) ? WPW'(ssum - WSW'(WAIT_DEPTH)) : WPW'(ssum);
  assign rsum  = WSW'(rhead_q) + WSW'(rcount_q);
  assign rtail = (rsum >= WSW'(WAIT_DEPTH)) ? WPW'(rsum - WSW'(WAIT_DEPTH)) : WPW'(rsum);

  assign vinc      = {1'b0, vhead_q} + 1'b1;
  assign vhead_inc = (vinc == (VPW + 1)'(BUFFER_DEPTH)) ? '0 : vinc[VPW-1:0];
  assign sinc      = {1'b0, shead_q} + 1'b1;
  assign shead_inc = (sinc == (WPW + 1)'(WAIT_DEPTH)) ? '0 : sinc[WPW-1:0];
  assign rinc      = {1'b0, rhead_q} + 1'b1;
  assign rhead_inc = (rinc == (WPW + 1)'(WAIT_DEPTH)) ? '0 : rinc[WPW-1:0];

  // effective capacity: zero acts as one, clamp to the buffer depth
  logic [CAPW-1:0] lim, cap;
  assign lim = CAPW'(limit_q);
  always_comb begin
    if (lim == '0) begin
      cap = CAPW'(1);
    end else if (lim > CAPW'(BUFFER_DEPTH)) begin
      cap = CAPW'(BUFFER_DEPTH);
    end else begin
      cap = lim;
    end
  end

  logic v_room, v_empty, s_full, s_any, r_full, r_any;
  assign v_room  = CAPW'(vcount_q) < cap;
  assign v_empty = (vcount_q == '0);
  assign s_full  = (scount_q == WCW'(WAIT_DEPTH));
  assign s_any   = (scount_q != '0);
  assign r_full  = (rcount_q == WCW'(WAIT_DEPTH));
  assign r_any   = (rcount_q != '0);

  // decision and result
  logic                  v_we, s_we, r_we;
  logic [DATA_WIDTH-1:0] v_wdata;

  always_comb begin
    res      = '0;
    v_we     = 1'b0;
    s_we     = 1'b0;
    r_we     = 1'b0;
    v_wdata  = data_q;
    vcount_d = vcount_q;
    vhead_d  = vhead_q;
    scount_d = scount_q;
    shead_d  = shead_q;
    rcount_d = rcount_q;
    rhead_d  = rhead_q;
    if (kind_q == KIND_SEND) begin
      priority if (r_any) begin
        // direct handoff to the oldest blocked receiver
        res.status           = STAT_SUSPEND;
        res.wake_valid       = 1'b1;
        res.wake_id          = rid_q;
        res.wake_at_front    = 1'b1;
        res.wake_value_valid = 1'b1;
        res.wake_value       = FIELD_W'(data_q);
        res.caller_requeued  = 1'b1;
        rhead_d              = rhead_inc;
        rcount_d             = rcount_q - 1'b1;
      end else if (v_room) begin
        res.status = STAT_CONTINUE;
        v_we       = 1'b1;
        vcount_d   = vcount_q + 1'b1;
      end else if (s_full) begin
        res.status = STAT_QFULL;
      end else begin
        res.status = STAT_SUSPEND;
        s_we       = 1'b1;
        scount_d   = scount_q + 1'b1;
      end
    end else begin
      priority if (v_empty && r_full) begin
        res.status = STAT_QFULL;
      end else if (v_empty) begin
        res.status = STAT_SUSPEND;
        r_we       = 1'b1;
        rcount_d   = rcount_q + 1'b1;
      end else begin
        // pop oldest value, refill from oldest blocked sender
        res.status     = STAT_CONTINUE;
        res.read_valid = 1'b1;
        res.read_value = FIELD_W'(vrd_q);
        vhead_d        = vhead_inc;
        if (s_any) begin
          v_we           = 1'b1;
          v_wdata        = sval_q;
          res.wake_valid = 1'b1;
          res.wake_id    = sid_q;
          shead_d        = shead_inc;
          scount_d       = scount_q - 1'b1;
        end else begin
          vcount_d = vcount_q - 1'b1;
        end
      end
    end
  end

  // memories: write on commit, read heads every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && v_we) begin
      vmem[vtail] <= v_wdata;
    end
    vrd_q <= vmem[vhead_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && s_we) begin
      smem_id[stail]  <= id_q;
      smem_val[stail] <= data_q;
    end
    sid_q  <= smem_id[shead_q];
    sval_q <= smem_val[shead_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && r_we) begin
      rmem_id[rtail] <= id_q;
    end
    rid_q <= rmem_id[rhead_q];
  end

  // request capture and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_item_i.kind;
      id_q   <= in_item_i.task_id;
      data_q <= in_item_i.data_in[DATA_WIDTH-1:0];
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  // pointers, counts and limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RST;
      vcount_q <= '0;
      vhead_q  <= '0;
      scount_q <= '0;
      shead_q  <= '0;
      rcount_q <= '0;
      rhead_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        vcount_q <= vcount_d;
        vhead_q  <= vhead_d;
        scount_q <= scount_d;
        shead_q  <= shead_d;
        rcount_q <= rcount_d;
        rhead_q  <= rhead_d;
      end
    end
  end

  assign out_item_o = out_q;

endmodule

@@ hw/rtl/buffered_channel_with_wait_queues.sv @@
// A request is captured; the fetch state reads its queue heads, and execute
// loads the result register once free; no new request is taken before that.
// Queue-head reads are registered memory reads that must settle before the
// state update. Reset: counts, heads and buffer_limit (16) reset at once;
// buffer and wait queue memories are not cleared and need no clearing pass.
module buffered_channel_with_wait_queues
  import bcwq_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 16,
  parameter int unsigned WAIT_DEPTH   = 16,
  parameter int unsigned DATA_WIDTH   = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bcwq_in_if.sink            in_i,
  bcwq_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i
);

  ctrl_cmd_t cmd;

  // sequencing
  bcwq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // queues and result
  bcwq_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .WAIT_DEPTH   (WAIT_DEPTH),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_i.payload),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_item_o  (out_o.payload)
  );

endmodule

@@ hw/rtl/bcwq_checker.sv @@
// Port-level checker for the channel, bound to the top level.
// Depends on bcwq_pkg and the assertion macro header.
`include "buffered_channel_with_wait_queues_assert.svh"

module bcwq_checker
  import bcwq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i
);

  logic in_acc;
  logic out_stall;
  logic read_ok;
  logic handoff_ok;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // a delivered value means the caller continues
  assign read_ok = !(out_valid_i && out_item_i.read_valid) ||
                   (out_item_i.status == STAT_CONTINUE && !out_item_i.caller_requeued);

  // handoff flags travel together
  assign handoff_ok = !(out_valid_i && out_item_i.wake_value_valid) ||
                      (out_item_i.wake_valid && out_item_i.wake_at_front &&
                       out_item_i.caller_requeued && out_item_i.status == STAT_SUSPEND);

  // a stalled result holds
  `BCWQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_item_i))

  // one request in flight: no transaction right after one
  `BCWQ_ASSERT_NEXT(a_in_gap, clk_i, rst_ni, in_acc, !in_ready_i)

  `BCWQ_ASSERT(a_read_cont, clk_i, rst_ni, read_ok)

  `BCWQ_ASSERT(a_handoff, clk_i, rst_ni, handoff_ok)

endmodule

bind buffered_channel_with_wait_queues bcwq_checker u_bcwq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);
